### hw/rtl/hashed_frame_deframer_top_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef HASHED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define HASHED_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every edge outside reset.
`define HFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deframer assertion failed");
// Condition must never be seen outside reset.
`define HFD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("deframer forbidden condition seen");
`else
`define HFD_ASSERT(label, clk, rst, prop)
`define HFD_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

### hw/rtl/hfd_pkg.sv
package hfd_pkg;

   localparam int HEADER_BYTES        = 164;
   localparam int DIGEST_AT           = 132;
   localparam int MAX_FRAME_BYTES_DEF = 65536;
   localparam int CFG_W               = 17;
   localparam int VER_W               = 16;
   localparam int POS_W               = 17;
   localparam int CSR_IDX_W           = 2;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [POS_W-1:0] HDR_LEN    = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] DIG_START  = POS_W'(DIGEST_AT);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION     = 2'd2;

   localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 17'd65372;
   localparam logic [CFG_W-1:0] MAX_FRAME_RESET   = 17'd65536;
   localparam logic [VER_W-1:0] VERSION_RESET     = 16'd1;

   localparam logic [3:0] ST_PENDING    = 4'd0;
   localparam logic [3:0] ST_GOOD       = 4'd1;
   localparam logic [3:0] ST_SHORT      = 4'd2;
   localparam logic [3:0] ST_MAGIC      = 4'd3;
   localparam logic [3:0] ST_VERSION    = 4'd4;
   localparam logic [3:0] ST_FLAGS      = 4'd5;
   localparam logic [3:0] ST_HDR_SIZE   = 4'd6;
   localparam logic [3:0] ST_LENGTHS    = 4'd7;
   localparam logic [3:0] ST_LIMITS     = 4'd8;
   localparam logic [3:0] ST_INTERVAL   = 4'd9;
   localparam logic [3:0] ST_TIMEBASE   = 4'd10;
   localparam logic [3:0] ST_DIGEST     = 4'd11;
   localparam logic [3:0] ST_BAD_CFG    = 4'd12;
   localparam logic [3:0] ST_STOPPED    = 4'd13;
   localparam logic [3:0] ST_INCOMPLETE = 4'd14;
   localparam logic [3:0] ST_FINISHED   = 4'd15;

   typedef struct packed {
      logic       op;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] frame_offset;
      logic        is_payload;
      logic        last_of_frame;
      logic [3:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] max_payload;
      logic [CFG_W-1:0] max_frame;
      logic [VER_W-1:0] expected_version;
   } cfg_type;

   // one queue slot: a byte to hash and/or a request to close the digest
   typedef struct packed {
      logic       has_byte;
      logic       fin;
      logic [7:0] data;
   } hash_entry_type;

   typedef struct packed {
      logic         done;
      logic [255:0] digest;
   } digest_type;

   typedef enum logic [1:0] {PH_ACCEPT, PH_STOPPED, PH_FINISHED} phase_type;
   typedef enum logic {FR_RUN, FR_WAIT} front_state_type;
   typedef enum logic [2:0] {SH_IDLE, SH_PAD, SH_ROUND, SH_ADD, SH_DONE} sha_state_type;

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

### hw/rtl/hfd_queue.sv
`include "hashed_frame_deframer_top_defines.svh"

module hfd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hfd_pkg::hash_entry_type push_entry,
   input  logic                   pop,
   output hfd_pkg::hash_entry_type head,
   output logic                   head_valid,
   output logic                   full
);
   import hfd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   hash_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, rd_ff;
   logic [CW-1:0]     cnt_ff;

   assign full       = (cnt_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ff] <= push_entry;
            wr_ff          <= wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + PW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   `HFD_ASSERT_NEVER(a_push_full, clock, reset, push && full)
   `HFD_ASSERT(a_pop_valid, clock, reset, pop |-> head_valid)

endmodule

### hw/rtl/hfd_sha.sv
`include "hashed_frame_deframer_top_defines.svh"

module hfd_sha (
   input  logic                   clock,
   input  logic                   reset,
   input  hfd_pkg::hash_entry_type head,
   input  logic                   head_valid,
   output logic                   pop,
   output hfd_pkg::digest_type    result
);
   import hfd_pkg::*;

   sha_state_type    state_ff, state_in;
   logic [511:0]     msg_ff;
   logic [31:0]      chain_ff [8];
   logic [31:0]      wk_ff [8];
   logic [5:0]       blk_ff;
   logic [5:0]       rnd_ff;
   logic [POS_W-1:0] len_ff;
   logic             fin_ff, mark_ff, lgo_ff, ldone_ff;
   logic [2:0]       lcnt_ff;

   logic             feed, real_byte, start_fin, pad, round, add, done, is_len;
   logic [7:0]       feed_byte;
   logic [63:0]      len_bits;
   logic [31:0]      t1, t2, w_new, w0;

   assign len_bits = {44'd0, len_ff, 3'b000};
   assign is_len   = !mark_ff && (lgo_ff || blk_ff == 6'd56);

   // round datapath
   always_comb begin
      w0    = msg_ff[511:480];
      w_new = w0 + small_sigma0(msg_ff[479:448]) + msg_ff[223:192]
            + small_sigma1(msg_ff[63:32]);
      t1    = wk_ff[7] + big_sigma1(wk_ff[4])
            + ((wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6])) + SHA_K[rnd_ff] + w0;
      t2    = big_sigma0(wk_ff[0])
            + ((wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SH_IDLE: begin
            if (head_valid) begin
               priority if (head.has_byte && blk_ff == 6'd63) state_in = SH_ROUND;
               else if (head.fin) state_in = SH_PAD;
               else state_in = SH_IDLE;
            end
         end
         SH_PAD:   state_in = (blk_ff == 6'd63) ? SH_ROUND : SH_PAD;
         SH_ROUND: state_in = (rnd_ff == 6'd63) ? SH_ADD : SH_ROUND;
         SH_ADD: begin
            priority if (!fin_ff) state_in = SH_IDLE;
            else if (ldone_ff) state_in = SH_DONE;
            else state_in = SH_PAD;
         end
         SH_DONE:  state_in = SH_IDLE;
         default:  state_in = SH_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      feed      = 1'b0;
      real_byte = 1'b0;
      start_fin = 1'b0;
      pad       = 1'b0;
      round     = 1'b0;
      add       = 1'b0;
      done      = 1'b0;
      feed_byte = head.data;
      unique case (state_ff)
         SH_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               feed      = head.has_byte;
               real_byte = head.has_byte;
               start_fin = head.fin;
            end
         end
         SH_PAD: begin
            feed = 1'b1;
            pad  = 1'b1;
            priority if (mark_ff) feed_byte = 8'h80;
            else if (is_len) feed_byte = 8'(len_bits >> {~lcnt_ff, 3'b000});
            else feed_byte = 8'h00;
         end
         SH_ROUND: round = 1'b1;
         SH_ADD:   add   = 1'b1;
         SH_DONE:  done  = 1'b1;
         default:  pop   = 1'b0;
      endcase
   end

   assign result.done   = done;
   assign result.digest = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3],
                           chain_ff[4], chain_ff[5], chain_ff[6], chain_ff[7]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SH_IDLE;
         chain_ff <= SHA_IV;
         len_ff   <= '0;
         blk_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (feed) begin
            msg_ff <= {msg_ff[503:0], feed_byte};
            blk_ff <= blk_ff + 6'd1;
            if (blk_ff == 6'd63) begin
               wk_ff  <= chain_ff;
               rnd_ff <= '0;
            end
         end
         if (real_byte) begin
            len_ff <= len_ff + POS_W'(1);
         end
         if (start_fin) begin
            fin_ff   <= 1'b1;
            mark_ff  <= 1'b1;
            lgo_ff   <= 1'b0;
            lcnt_ff  <= '0;
            ldone_ff <= 1'b0;
         end
         if (pad) begin
            if (mark_ff) begin
               mark_ff <= 1'b0;
            end else if (is_len) begin
               lgo_ff  <= 1'b1;
               lcnt_ff <= lcnt_ff + 3'd1;
               if (lcnt_ff == 3'd7) begin
                  ldone_ff <= 1'b1;
               end
            end
         end
         if (round) begin
            wk_ff[0] <= t1 + t2;
            wk_ff[1] <= wk_ff[0];
            wk_ff[2] <= wk_ff[1];
            wk_ff[3] <= wk_ff[2];
            wk_ff[4] <= wk_ff[3] + t1;
            wk_ff[5] <= wk_ff[4];
            wk_ff[6] <= wk_ff[5];
            wk_ff[7] <= wk_ff[6];
            msg_ff   <= {msg_ff[479:0], w_new};
            rnd_ff   <= rnd_ff + 6'd1;
         end
         if (add) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + wk_ff[i];
            end
         end
         if (done) begin
            chain_ff <= SHA_IV;
            len_ff   <= '0;
            fin_ff   <= 1'b0;
         end
      end
   end

   `HFD_ASSERT(a_done_single, clock, reset, result.done |=> !result.done)

endmodule

### hw/rtl/hfd_front.sv
`include "hashed_frame_deframer_top_defines.svh"

module hfd_front #(
   parameter int MAX_FRAME_BYTES = hfd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hfd_pkg::cfg_type        cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hfd_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hfd_pkg::rsp_type        rsp_data,
   output logic                    push,
   output hfd_pkg::hash_entry_type push_entry,
   input  logic                    q_full,
   input  hfd_pkg::digest_type     hash_result
);
   import hfd_pkg::*;

   localparam int MAXW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMPW = (MAXW > CFG_W) ? MAXW : CFG_W;
   localparam logic [CMPW-1:0] MAX_LIMIT = CMPW'(MAX_FRAME_BYTES);
   localparam int FLD_N       = 6;
   localparam int FLD_TOTAL   = 0;
   localparam int FLD_PAYLOAD = 1;
   localparam int FLD_START   = 2;
   localparam int FLD_END     = 3;
   localparam int FLD_NUM     = 4;
   localparam int FLD_DEN     = 5;
   localparam logic [7:0] FIELD_AT [FLD_N] = '{8'd12, 8'd124, 8'd60, 8'd68, 8'd108, 8'd116};
   localparam logic [7:0] MAGIC [4] = '{"C", "M", "X", "1"};
   localparam logic [31:0] HDR_WORD = 32'(HEADER_BYTES);
   localparam int FL_MAGIC = 0;
   localparam int FL_VER   = 1;
   localparam int FL_FLAGS = 2;
   localparam int FL_SIZE  = 3;

   front_state_type  state_ff, state_in;
   phase_type        phase_ff;
   logic [POS_W-1:0] pos_ff;
   logic [3:0]       flag_ff;
   logic [63:0]      fld_ff [FLD_N];
   logic [255:0]     dig_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             acc, cfg_ok, overrun, total_big, at_end, hdr_seen;
   logic             len_bad, lim_bad, int_bad, tb_bad, hashed, absorb, need_dig, dig_good;
   logic [POS_W-1:0] n;
   logic [63:0]      total;
   logic [3:0]       st;
   rsp_type          res;
   logic [7:0]       b;

   assign b     = req_data.in_byte;
   assign n     = pos_ff + POS_W'(1);
   assign total = fld_ff[FLD_TOTAL];

   always_comb begin
      cfg_ok    = (cfg.max_payload != '0) && (cfg.max_frame != '0)
                && (cfg.max_frame >= HDR_LEN) && (CMPW'(cfg.max_frame) <= MAX_LIMIT)
                && (cfg.max_payload <= cfg.max_frame - HDR_LEN);
      overrun   = pos_ff >= cfg.max_frame;
      total_big = total > 64'(cfg.max_frame);
      at_end    = 64'(n) >= total;
      hdr_seen  = n >= HDR_LEN;
      len_bad   = fld_ff[FLD_PAYLOAD] != (total - 64'(HEADER_BYTES));
      lim_bad   = fld_ff[FLD_PAYLOAD] > 64'(cfg.max_payload);
      int_bad   = $signed(fld_ff[FLD_END]) < $signed(fld_ff[FLD_START]);
      tb_bad    = (fld_ff[FLD_NUM] == '0) || fld_ff[FLD_NUM][63]
                || (fld_ff[FLD_DEN] == '0) || fld_ff[FLD_DEN][63];
      hashed    = (pos_ff < DIG_START) || (pos_ff >= HDR_LEN);
      dig_good  = hash_result.digest == dig_ff;
   end

   // classify the word at the head of the request channel
   always_comb begin
      st       = ST_PENDING;
      need_dig = 1'b0;
      absorb   = 1'b0;
      res      = '0;
      if (req_data.op) begin
         priority if (phase_ff == PH_STOPPED) st = ST_STOPPED;
         else if (pos_ff != '0) st = ST_INCOMPLETE;
         else st = ST_FINISHED;
      end else if (phase_ff != PH_ACCEPT) begin
         st = ST_STOPPED;
      end else begin
         res.out_byte     = b;
         res.frame_offset = pos_ff[15:0];
         res.is_payload   = pos_ff >= HDR_LEN;
         priority if (!cfg_ok) st = ST_BAD_CFG;
         else if (overrun) st = ST_LIMITS;
         else begin
            absorb = 1'b1;
            if (hdr_seen) begin
               priority if (total_big) st = ST_LIMITS;
               else if (!at_end) st = ST_PENDING;
               else if (total < 64'(HEADER_BYTES)) st = ST_SHORT;
               else if (flag_ff[FL_MAGIC]) st = ST_MAGIC;
               else if (flag_ff[FL_VER]) st = ST_VERSION;
               else if (flag_ff[FL_FLAGS]) st = ST_FLAGS;
               else if (flag_ff[FL_SIZE]) st = ST_HDR_SIZE;
               else if (len_bad) st = ST_LENGTHS;
               else if (lim_bad) st = ST_LIMITS;
               else if (int_bad) st = ST_INTERVAL;
               else if (tb_bad) st = ST_TIMEBASE;
               else need_dig = 1'b1;
            end
         end
      end
      res.status        = st;
      res.last_of_frame = st != ST_PENDING;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_RUN:  if (acc && need_dig) state_in = FR_WAIT;
         FR_WAIT: if (hash_result.done) state_in = FR_RUN;
         default: state_in = FR_RUN;
      endcase
   end

   always_comb begin
      req_stall           = (state_ff == FR_WAIT) || q_full || (rsp_valid_ff && rsp_stall);
      acc                 = req_valid && !req_stall;
      push                = acc && ((absorb && hashed) || need_dig);
      push_entry.has_byte = absorb && hashed;
      push_entry.fin      = need_dig;
      push_entry.data     = b;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FR_RUN;
         phase_ff     <= PH_ACCEPT;
         pos_ff       <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // hold a stalled word, load a new one, or raise the verdict word
         rsp_valid_ff <= (rsp_valid_ff && rsp_stall) || (acc && !need_dig)
                       || (state_ff == FR_WAIT && hash_result.done);
         if (acc) begin
            rsp_data_ff <= res;
            if (req_data.op) begin
               if (phase_ff != PH_STOPPED) begin
                  phase_ff <= (pos_ff != '0) ? PH_STOPPED : PH_FINISHED;
               end
            end else if (phase_ff == PH_ACCEPT && st != ST_PENDING) begin
               phase_ff <= PH_STOPPED;
            end
            if (absorb) begin
               pos_ff <= n;
               if (pos_ff < POS_W'(4) && b != MAGIC[pos_ff[1:0]]) flag_ff[FL_MAGIC] <= 1'b1;
               if ((pos_ff == POS_W'(4) && b != cfg.expected_version[7:0])
                   || (pos_ff == POS_W'(5) && b != cfg.expected_version[15:8])) begin
                  flag_ff[FL_VER] <= 1'b1;
               end
               if ((pos_ff == POS_W'(6) || pos_ff == POS_W'(7)) && b != 8'h00) begin
                  flag_ff[FL_FLAGS] <= 1'b1;
               end
               if (pos_ff >= POS_W'(8) && pos_ff < POS_W'(12)
                   && b != HDR_WORD[{pos_ff[1:0], 3'b000} +: 8]) begin
                  flag_ff[FL_SIZE] <= 1'b1;
               end
               for (int i = 0; i < FLD_N; i++) begin
                  if (pos_ff >= POS_W'(FIELD_AT[i]) && pos_ff < POS_W'(FIELD_AT[i]) + POS_W'(8)) begin
                     fld_ff[i] <= {b, fld_ff[i][63:8]};
                  end
               end
               if (pos_ff >= DIG_START && pos_ff < HDR_LEN) begin
                  dig_ff <= {dig_ff[247:0], b};
               end
            end
         end
         if (state_ff == FR_WAIT && hash_result.done) begin
            rsp_data_ff.status        <= dig_good ? ST_GOOD : ST_DIGEST;
            rsp_data_ff.last_of_frame <= 1'b1;
            if (dig_good) begin
               pos_ff  <= '0;
               flag_ff <= '0;
            end else begin
               phase_ff <= PH_STOPPED;
            end
         end
      end
   end

   `HFD_ASSERT(a_wait_stalls, clock, reset, (state_ff == FR_WAIT) |-> req_stall)
   `HFD_ASSERT(a_push_accepting, clock, reset, push |-> (phase_ff == PH_ACCEPT))
   `HFD_ASSERT_NEVER(a_done_idle, clock, reset, hash_result.done && state_ff != FR_WAIT)

endmodule

### hw/rtl/hashed_frame_deframer_top.sv
// Frame stream checker: one word per request, a stream byte (op 0) or an end-of-stream
// marker (op 1), and exactly one response word per request, in order. Each frame is a
// 164-byte little-endian header plus payload; bytes come straight back with their frame
// offset and payload mark, and the last byte of a frame carries the verdict (good, or the
// first failing check), so downstream must drop any frame whose verdict is not good. Any
// failure latches a stopped state until reset. A byte is taken while the hash queue has
// room, no verdict is awaited and no stalled response word is held; the SHA-256 engine
// behind it takes each byte from the queue, then compresses each full 64-byte block one
// round at a time. The last byte of a frame waits for padding and the closing one or two
// block compressions before its verdict appears. No clearing pass follows reset. Write the
// configuration registers only while the block is idle.
module hashed_frame_deframer_top #(
   parameter int MAX_FRAME_BYTES = hfd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  hfd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output hfd_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hfd_pkg::CFG_W-1:0]       csr_data
);
   import hfd_pkg::*;

   // configuration registers, reset to their documented defaults
   cfg_type        cfg_ff;

   // front-to-back hash queue
   logic           q_push, q_pop, q_full, q_head_valid;
   hash_entry_type q_push_entry, q_head;
   digest_type     hash_result;

   // the register file never backpressures
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload      <= MAX_PAYLOAD_RESET;
         cfg_ff.max_frame        <= MAX_FRAME_RESET;
         cfg_ff.expected_version <= VERSION_RESET;
      end else if (csr_valid && csr_ready) begin
         // drop writes to an index past the register list
         unique case (csr_index)
            CSR_MAX_PAYLOAD: cfg_ff.max_payload      <= csr_data;
            CSR_MAX_FRAME:   cfg_ff.max_frame        <= csr_data;
            CSR_VERSION:     cfg_ff.expected_version <= csr_data[VER_W-1:0];
            default:         cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // front: accept, track frame offset, parse header, judge, hold the response word
   hfd_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .push        (q_push),
      .push_entry  (q_push_entry),
      .q_full      (q_full),
      .hash_result (hash_result)
   );

   // short queue so the front keeps taking bytes while a block compresses, until it fills
   hfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid),
      .full       (q_full)
   );

   // back: SHA-256, one round per cycle, padding fed byte by byte
   hfd_sha u_sha (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .result     (hash_result)
   );

endmodule
